// ----- sv/rsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Row seat allocator package
// Shared widths, codes and types for the row seat allocator.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int unsigned SeatW     = 30;
  localparam int unsigned RowIdxW   = 10;
  localparam int unsigned RowCntW   = 11;
  localparam int unsigned SumW      = 41;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned DefRows   = 1024;
  localparam logic [SeatW-1:0]   SeatsReset = 30'd1;
  localparam logic [RowCntW-1:0] RowCntReset = 11'd1024;

  localparam logic [CfgIdxW-1:0] CfgSeatsPerRow = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgRowCount    = 1'b1;

  localparam logic CmdContig  = 1'b0;
  localparam logic CmdScatter = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StCheck,
    StCtgRead,
    StCtgTest,
    StSumRead,
    StSumAdd,
    StScRead,
    StScTake,
    StDone
  } state_e;

endpackage

// ----- sv/rsa_if.sv -----
// ----------------------------------------------------------------------------
// Row seat allocator channels
// Valid/ready request, result and configuration channels.
// ----------------------------------------------------------------------------
interface rsa_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [29:0] group_size;
  logic [9:0]  max_row;
  modport source (output valid, command, group_size, max_row, input ready);
  modport sink   (input valid, command, group_size, max_row, output ready);
endinterface

interface rsa_rsp_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic [9:0]  row_index;
  logic [29:0] first_seat;
  modport source (output valid, granted, row_index, first_seat, input ready);
  modport sink   (input valid, granted, row_index, first_seat, output ready);
endinterface

interface rsa_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [29:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/rsa_row_mem.sv -----
// ----------------------------------------------------------------------------
// Row free-count memory
// One write port and one registered read port holding each row's free count.
// ----------------------------------------------------------------------------
module rsa_row_mem
  import rsa_pkg::*;
#(
  parameter int unsigned Rows = DefRows
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Rows)-1:0]  waddr_i,
  input  logic [SeatW-1:0]         wdata_i,
  input  logic [$clog2(Rows)-1:0]  raddr_i,
  output logic [SeatW-1:0]         rdata_o
);

  logic [SeatW-1:0] mem_q [Rows];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/row_seat_allocator.sv -----
// ----------------------------------------------------------------------------
// Row seat allocator
// Hands out contiguous or scattered seat groups over a hall of rows.
// ----------------------------------------------------------------------------
// Each row's free count lives in a single-port-write, registered-read memory,
// and one request at a time is worked through by a small sequencer that
// reads a row and then acts on it. A contiguous request scans rows from 0
// upwards and stops at the first row that fits, or is refused once max_row
// has been tested. A scattered request first sums rows from the first open
// row to max_row, then takes seats from the first open row upwards. A refused
// request for an out-of-range row goes from the check straight to done.
// After reset and after every configuration write a clearing pass refills
// all Rows entries, one a cycle unless a further configuration write
// restarts it, and the next request is accepted only once it is done;
// configuration writes are taken at any time the block is idle or clearing,
// and a write offered while idle holds off any request offered in the same
// cycle. The result sits in an output register until taken, and only then
// is a new request taken.
// ----------------------------------------------------------------------------
module row_seat_allocator
  import rsa_pkg::*;
#(
  parameter int unsigned Rows = DefRows
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rsa_cfg_if.sink   cfg_i,
  rsa_req_if.sink   req_i,
  rsa_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(Rows);
  localparam logic [RowCntW+6:0] RowsC = (RowCntW+7)'(Rows);

  state_e state_q, state_d;

  logic [SeatW-1:0]   seats_q, seats_d;
  logic [RowCntW-1:0] rcnt_q, rcnt_d;
  logic [AW:0]        ptr_q, ptr_d;       // row cursor
  logic [AW:0]        open_q, open_d;     // first open row
  logic               cmd_q, cmd_d;
  logic [SeatW-1:0]   need_q, need_d;
  logic [RowIdxW-1:0] maxr_q, maxr_d;
  logic [SumW-1:0]    acc_q, acc_d;
  logic               gnt_q, gnt_d;
  logic [RowIdxW-1:0] row_q, row_d;
  logic [SeatW-1:0]   seat_q, seat_d;
  logic               vld_q, vld_d;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [SeatW-1:0]   wdata;
  logic [SeatW-1:0]   rdata;

  logic [RowCntW+6:0] in_use;
  logic               cfg_fire, req_fire;
  logic [SumW-1:0]    add_res;
  logic               row_ok;

  rsa_row_mem #(.Rows(Rows)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign in_use = ((RowCntW+7)'(rcnt_q) < RowsC) ? (RowCntW+7)'(rcnt_q) : RowsC;
  assign cfg_i.ready = (state_q == StIdle) || (state_q == StClear);
  // A configuration write wins over a request offered in the same idle cycle.
  assign req_i.ready = (state_q == StIdle) && !vld_q && !cfg_i.valid;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_o.valid = vld_q;
  assign rsp_o.granted = gnt_q;
  assign rsp_o.row_index = row_q;
  assign rsp_o.first_seat = seat_q;

  // The sum adder: accumulates row free counts for scattered requests.
  assign add_res = acc_q + SumW'(rdata);
  // Cursor still inside the scan window.
  assign row_ok = ((RowCntW+7)'(ptr_q) <= (RowCntW+7)'(maxr_q)) &&
                  ((RowCntW+7)'(ptr_q) < RowsC);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cfg_fire) state_d = StClear;
        else if (req_fire) state_d = StCheck;
      end
      StClear: begin
        if (!cfg_fire && (RowCntW+7)'(ptr_q) == RowsC - 1'b1) state_d = StIdle;
      end
      StCheck: begin
        if ((RowCntW+7)'(maxr_q) >= in_use) state_d = StDone;
        else if (cmd_q == CmdContig) state_d = StCtgRead;
        else state_d = StSumRead;
      end
      StCtgRead: state_d = StCtgTest;
      StCtgTest: begin
        if (rdata >= need_q || (RowCntW+7)'(ptr_q) == (RowCntW+7)'(maxr_q))
          state_d = StDone;
        else state_d = StCtgRead;
      end
      StSumRead: state_d = row_ok ? StSumAdd : StScRead;
      StSumAdd:  state_d = StSumRead;
      StScRead: begin
        if (acc_q < SumW'(need_q) || need_q == '0 || ptr_q == (AW+1)'(Rows))
          state_d = StDone;
        else state_d = StScTake;
      end
      StScTake: state_d = StScRead;
      StDone:   state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Datapath and outputs of each state.
  always_comb begin
    seats_d = seats_q; rcnt_d = rcnt_q; ptr_d = ptr_q; open_d = open_q;
    cmd_d = cmd_q; need_d = need_q; maxr_d = maxr_q; acc_d = acc_q;
    gnt_d = gnt_q; row_d = row_q; seat_d = seat_q; vld_d = vld_q;
    we = 1'b0; waddr = ptr_q[AW-1:0]; wdata = seats_q;
    if (vld_q && rsp_o.ready) vld_d = 1'b0;
    if (cfg_fire) begin
      if (cfg_i.index == CfgSeatsPerRow) seats_d = cfg_i.data;
      else rcnt_d = cfg_i.data[RowCntW-1:0];
      ptr_d = '0;
      open_d = '0;
    end
    case (state_q)
      StIdle: begin
        if (req_fire && !cfg_fire) begin
          cmd_d = req_i.command;
          need_d = req_i.group_size;
          maxr_d = req_i.max_row;
          gnt_d = 1'b0; row_d = '0; seat_d = '0;
        end
      end
      StClear: begin
        if (!cfg_fire) begin
          we = 1'b1;
          wdata = seats_q;
          ptr_d = ptr_q + 1'b1;
        end
      end
      StCheck: begin
        acc_d = '0;
        ptr_d = (cmd_q == CmdContig) ? '0 : open_q;
      end
      StCtgRead: ;
      StCtgTest: begin
        if (rdata >= need_q) begin
          gnt_d = 1'b1;
          row_d = RowIdxW'(ptr_q);
          seat_d = seats_q - rdata;
          we = 1'b1;
          wdata = rdata - need_q;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      StSumRead: begin
        if (!row_ok) ptr_d = open_q;
      end
      StSumAdd: begin
        acc_d = add_res;
        ptr_d = ptr_q + 1'b1;
      end
      StScRead: begin
        if (acc_q >= SumW'(need_q)) gnt_d = 1'b1;
      end
      StScTake: begin
        we = 1'b1;
        if (rdata < need_q) begin
          wdata = '0;
          need_d = need_q - rdata;
        end else begin
          wdata = rdata - need_q;
          need_d = '0;
        end
        if (wdata == '0) begin
          ptr_d = ptr_q + 1'b1;
          open_d = ptr_q + 1'b1;
        end
      end
      StDone: vld_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      seats_q <= SeatsReset;
      rcnt_q  <= RowCntReset;
      ptr_q   <= '0;
      open_q  <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      seats_q <= seats_d;
      rcnt_q  <= rcnt_d;
      ptr_q   <= ptr_d;
      open_q  <= open_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    need_q <= need_d;
    maxr_q <= maxr_d;
    acc_q  <= acc_d;
    gnt_q  <= gnt_d;
    row_q  <= row_d;
    seat_q <= seat_d;
  end

endmodule

// ----- sv/rsa_checker.sv -----
// ----------------------------------------------------------------------------
// Row seat allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_granted,
  input logic [9:0]  rsp_row_index,
  input logic [29:0] rsp_first_seat
);

  // One request in flight: no new request while a result waits.
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("request taken while result pending");

  // A refusal reports no row and no seat.
  a_refusal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_granted) |-> (rsp_row_index == '0 && rsp_first_seat == '0))
    else $error("refusal carries a row or seat");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_granted) &&
    $stable(rsp_row_index) && $stable(rsp_first_seat)))
    else $error("result changed while stalled");

  // An accepted request is not followed by another acceptance next cycle.
  a_no_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready) |=> !req_ready) else $error("back-to-back accept");

endmodule

bind row_seat_allocator rsa_checker u_rsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid      (req_i.valid),
  .req_ready      (req_i.ready),
  .rsp_valid      (rsp_o.valid),
  .rsp_ready      (rsp_o.ready),
  .rsp_granted    (rsp_o.granted),
  .rsp_row_index  (rsp_o.row_index),
  .rsp_first_seat (rsp_o.first_seat)
);
